// ===== rtl/core/mtw_pkg.sv =====
// Shared types, codes and constants for the table-walk translation block.
`timescale 1ns / 1ps

package mtw_pkg;

	// Default sizes, handed to the top-level parameters
	localparam int MEM_WORDS_DEF = 4096;
	localparam int MAX_STEPS_DEF = 8;

	// Depth of the queue between the front and back ends
	localparam int QUEUE_DEPTH = 2;

	// Field widths fixed by the interface
	localparam int ADDR_FIELD_W = 12;
	localparam int DATA_W       = 32;
	localparam int CFG_IDX_W    = 4;

	// Command codes on the input channel
	localparam logic CMD_WRITE     = 1'b0;
	localparam logic CMD_TRANSLATE = 1'b1;

	// Descriptor type codes
	localparam logic [1:0] DT_NONE  = 2'd0;
	localparam logic [1:0] DT_PAGE  = 2'd1;
	localparam logic [1:0] DT_SHORT = 2'd2;
	localparam logic [1:0] DT_LONG  = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TRANSLATE_ENABLE = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROOT_TYPE        = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROOT_TABLE_ADDR  = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PAGE_SHIFT       = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH_A          = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH_B          = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH_C          = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH_D          = 4'd7;

	localparam logic [3:0] PAGE_SHIFT_RESET = 4'd12;

	// What the back end has to do with a queued item
	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_PASS  = 2'd1,
		KIND_WALK  = 2'd2
	} kind_t;

	// One queued item: data is the descriptor word or the virtual address
	typedef struct packed {
		kind_t                   kind;
		logic [ADDR_FIELD_W-1:0] addr;
		logic [DATA_W-1:0]       data;
	} entry_t;

	// Configuration register file
	typedef struct packed {
		logic             translate_enable;
		logic [1:0]       root_type;
		logic [27:0]      root_table_addr;
		logic [3:0]       page_shift;
		logic [3:0][3:0]  level_width;
	} cfg_t;

endpackage

// ===== rtl/core/mtw_front.sv =====
// Front end: accepts input beats, classifies them and queues them for the back end.
`timescale 1ns / 1ps

module mtw_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 cmd,
	input  logic [mtw_pkg::ADDR_FIELD_W-1:0]     mem_addr,
	input  logic [mtw_pkg::DATA_W-1:0]           mem_data,
	input  logic [mtw_pkg::DATA_W-1:0]           virt_addr,
	input  logic                                 translate_enable,
	output logic                                 head_valid,
	output mtw_pkg::entry_t                      head,
	input  logic                                 pop
);
	import mtw_pkg::*;

	localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	entry_t          queue_q [QUEUE_DEPTH];
	logic [QW-1:0]   wr_ptr_q;
	logic [QW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	entry_t          entry;
	logic            push;
	logic            do_pop;

	// Classify the incoming beat
	always_comb begin
		entry.addr = mem_addr;
		if (cmd == CMD_WRITE) begin
			entry.kind = KIND_WRITE;
			entry.data = mem_data;
		end else begin
			entry.kind = translate_enable ? KIND_WALK : KIND_PASS;
			entry.data = virt_addr;
		end
	end

	assign in_ready   = (count_q != CW'(QUEUE_DEPTH));
	assign push       = in_valid && in_ready;
	assign head_valid = (count_q != '0);
	assign do_pop     = pop && head_valid;
	assign head       = queue_q[rd_ptr_q];

	// Store queued entries
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= entry;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QW'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (!push && do_pop) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ===== rtl/core/mtw_back.sv =====
// Back end: descriptor memory, table-walk sequencer and result register.
`timescale 1ns / 1ps

module mtw_back #(
	parameter int MEM_WORDS = mtw_pkg::MEM_WORDS_DEF,
	parameter int MAX_STEPS = mtw_pkg::MAX_STEPS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mtw_pkg::cfg_t                 cfg,
	input  logic                          head_valid,
	input  mtw_pkg::entry_t               head,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [mtw_pkg::DATA_W-1:0]    phys_addr,
	output logic                          fault
);
	import mtw_pkg::*;

	localparam int AW = $clog2(MEM_WORDS);
	localparam int SW = $clog2(MAX_STEPS + 1);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_EVAL  = 4'b0010,
		ST_LOAD0 = 4'b0100,
		ST_LOAD1 = 4'b1000
	} state_t;

	state_t         state_q;
	state_t         state_d;

	// Descriptor memory
	logic [31:0]    mem [MEM_WORDS];
	logic [31:0]    rd_data_q;
	logic           mem_we;
	logic           rd_en;
	logic [AW-1:0]  rd_addr;
	logic [AW-1:0]  wr_idx;

	// Walk state
	logic [31:0]    va_q;
	logic [31:0]    va_sh_q;
	logic [31:0]    mask_q;
	logic [1:0]     w0_q;
	logic [31:0]    w1_q;
	logic [2:0]     level_q;
	logic [SW-1:0]  steps_q;
	logic           long_q;
	logic [AW-1:0]  word_q;

	// Result register
	logic           res_valid_q;
	logic [31:0]    res_phys_q;
	logic           res_fault_q;
	logic           res_load;
	logic [31:0]    res_phys_d;
	logic           res_fault_d;

	logic           slot_free;
	logic           start_walk;
	logic           step_issue;
	logic [3:0]     width;
	logic [14:0]    idx;
	logic           is_long;
	logic [31:0]    offs;
	logic [31:0]    p;
	logic [31:0]    frame_mask;
	logic [31:0]    page_phys;
	logic           overrun;

	assign slot_free  = !res_valid_q || out_ready;
	assign width      = cfg.level_width[level_q[1:0]];
	assign idx        = va_sh_q[31:17] >> (4'd15 - width);
	assign is_long    = (w0_q == DT_LONG);
	assign offs       = is_long ? {14'b0, idx, 3'b0} : {15'b0, idx, 2'b0};
	assign p          = {w1_q[31:4], 4'b0} + offs;
	assign frame_mask = 32'hFFFF_FF00 & (32'hFFFF_FFFF << cfg.page_shift);
	assign page_phys  = (w1_q & frame_mask) + (va_q & mask_q);
	assign overrun    = (level_q >= 3'd4) || (steps_q >= SW'(MAX_STEPS));
	assign wr_idx     = AW'({20'b0, head.addr});

	// Sequence items and walk steps
	always_comb begin
		state_d     = state_q;
		pop         = 1'b0;
		mem_we      = 1'b0;
		rd_en       = 1'b0;
		rd_addr     = p[AW+1:2];
		res_load    = 1'b0;
		res_phys_d  = '0;
		res_fault_d = 1'b0;
		start_walk  = 1'b0;
		step_issue  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (head_valid) begin
					case (head.kind)
						KIND_WRITE: begin
							if (slot_free) begin
								pop      = 1'b1;
								mem_we   = 1'b1;
								res_load = 1'b1;
							end
						end
						KIND_PASS: begin
							if (slot_free) begin
								pop        = 1'b1;
								res_load   = 1'b1;
								res_phys_d = head.data;
							end
						end
						KIND_WALK: begin
							pop        = 1'b1;
							start_walk = 1'b1;
							state_d    = ST_EVAL;
						end
						default: begin
							pop = 1'b1;
						end
					endcase
				end
			end
			ST_EVAL: begin
				if (w0_q == DT_NONE || (w0_q != DT_PAGE && overrun)) begin
					if (slot_free) begin
						res_load    = 1'b1;
						res_fault_d = 1'b1;
						state_d     = ST_IDLE;
					end
				end else if (w0_q == DT_PAGE) begin
					if (slot_free) begin
						res_load   = 1'b1;
						res_phys_d = page_phys;
						state_d    = ST_IDLE;
					end
				end else begin
					step_issue = 1'b1;
					rd_en      = 1'b1;
					state_d    = ST_LOAD0;
				end
			end
			ST_LOAD0: begin
				if (long_q) begin
					rd_en   = 1'b1;
					rd_addr = word_q + AW'(1);
					state_d = ST_LOAD1;
				end else begin
					state_d = ST_EVAL;
				end
			end
			ST_LOAD1: begin
				state_d = ST_EVAL;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Write and read the descriptor memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_idx] <= head.data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Hold walk payload
	always_ff @(posedge clk) begin
		if (start_walk) begin
			va_q    <= head.data;
			va_sh_q <= head.data;
			mask_q  <= 32'hFFFF_FFFF;
			w0_q    <= cfg.root_type;
			w1_q    <= {cfg.root_table_addr, 4'b0};
		end else if (step_issue) begin
			long_q <= is_long;
			word_q <= p[AW+1:2];
			if (width != 4'd0) begin
				va_sh_q <= va_sh_q << width;
				mask_q  <= mask_q >> width;
			end
		end else if (state_q == ST_LOAD0) begin
			w0_q <= rd_data_q[1:0];
			if (!long_q) begin
				w1_q <= rd_data_q;
			end
		end else if (state_q == ST_LOAD1) begin
			w1_q <= rd_data_q;
		end
		if (res_load) begin
			res_phys_q  <= res_phys_d;
			res_fault_q <= res_fault_d;
		end
	end

	// Advance control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
			level_q     <= '0;
			steps_q     <= '0;
		end else begin
			state_q <= state_d;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (out_ready) begin
				res_valid_q <= 1'b0;
			end
			if (start_walk) begin
				level_q <= '0;
				steps_q <= '0;
			end else if (step_issue) begin
				steps_q <= steps_q + SW'(1);
				if (width != 4'd0) begin
					level_q <= level_q + 3'd1;
				end
			end
		end
	end

	assign out_valid = res_valid_q;
	assign phys_addr = res_phys_q;
	assign fault     = res_fault_q;

endmodule

// ===== rtl/core/mmu_table_walk_translate.sv =====
// Top level of the table-walk address translation block.
`timescale 1ns / 1ps

// Translates 32-bit virtual addresses by walking a descriptor tree of up to four
// levels held in an on-chip descriptor RAM of MEM_WORDS 32-bit words (a power of
// two; word addresses wrap). Items with cmd 0 write one RAM word; items with cmd 1
// translate, and every item returns exactly one result beat, in order. Inputs go
// into a two-entry queue, so new beats are taken while the back end works or a
// result waits. A walk makes at most MAX_STEPS fetches, one at a time through the
// RAM's registered read port; a long-table fetch reads two words. The RAM is not
// cleared; a walk through a word never written gives an undefined result. The
// user must write configuration only while the block is idle; the block does not
// enforce this, and cfg_ready is always high.
module mmu_table_walk_translate #(
	parameter int MEM_WORDS = mtw_pkg::MEM_WORDS_DEF,
	parameter int MAX_STEPS = mtw_pkg::MAX_STEPS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mtw_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mtw_pkg::DATA_W-1:0]        cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              cmd,
	input  logic [mtw_pkg::ADDR_FIELD_W-1:0]  mem_addr,
	input  logic [mtw_pkg::DATA_W-1:0]        mem_data,
	input  logic [mtw_pkg::DATA_W-1:0]        virt_addr,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [mtw_pkg::DATA_W-1:0]        phys_addr,
	output logic                              fault
);
	import mtw_pkg::*;

	cfg_t    cfg_q;
	logic    head_valid;
	entry_t  head;
	logic    pop;

	assign cfg_ready = 1'b1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.translate_enable <= 1'b0;
			cfg_q.root_type        <= DT_NONE;
			cfg_q.root_table_addr  <= '0;
			cfg_q.page_shift       <= PAGE_SHIFT_RESET;
			cfg_q.level_width      <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TRANSLATE_ENABLE: cfg_q.translate_enable <= cfg_data[0];
				REG_ROOT_TYPE:        cfg_q.root_type        <= cfg_data[1:0];
				REG_ROOT_TABLE_ADDR:  cfg_q.root_table_addr  <= cfg_data[27:0];
				REG_PAGE_SHIFT:       cfg_q.page_shift       <= cfg_data[3:0];
				REG_WIDTH_A:          cfg_q.level_width[0]   <= cfg_data[3:0];
				REG_WIDTH_B:          cfg_q.level_width[1]   <= cfg_data[3:0];
				REG_WIDTH_C:          cfg_q.level_width[2]   <= cfg_data[3:0];
				REG_WIDTH_D:          cfg_q.level_width[3]   <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	mtw_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.cmd              (cmd),
		.mem_addr         (mem_addr),
		.mem_data         (mem_data),
		.virt_addr        (virt_addr),
		.translate_enable (cfg_q.translate_enable),
		.head_valid       (head_valid),
		.head             (head),
		.pop              (pop)
	);

	mtw_back #(
		.MEM_WORDS (MEM_WORDS),
		.MAX_STEPS (MAX_STEPS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.phys_addr  (phys_addr),
		.fault      (fault)
	);

endmodule

// ===== rtl/core/mtw_checker.sv =====
// Port-level checks for the table-walk translation block, bound to its top level.
`timescale 1ns / 1ps

module mtw_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] phys_addr,
	input  logic        fault
);
	// Queue, walker and result register together hold at most this many items
	localparam logic [3:0] MAX_PENDING = 4'd4;

	logic [3:0] pending_q;
	logic       in_beat;
	logic       out_beat;

	assign in_beat  = in_valid && in_ready;
	assign out_beat = out_valid && out_ready;

	// Count items taken in and not yet returned
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_beat && !out_beat) begin
			pending_q <= pending_q + 4'd1;
		end else if (!in_beat && out_beat) begin
			pending_q <= pending_q - 4'd1;
		end
	end

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(phys_addr) && $stable(fault))
		else $error("result changed while stalled");

	// Drive a zero address with every fault
	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fault |-> phys_addr == 32'd0)
		else $error("fault with nonzero address");

	// Present no result that was not caused by an input beat
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 4'd0)
		else $error("result without a pending item");

	// Bound the items in flight
	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= MAX_PENDING)
		else $error("more items in flight than storage allows");

endmodule

bind mmu_table_walk_translate mtw_checker u_mtw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.phys_addr (phys_addr),
	.fault     (fault)
);

// ===== test/tb_mmu_table_walk_translate.sv =====
// Testbench for the table-walk translation block: directed walks, back-pressure and random traffic.
`timescale 1ns / 1ps

module tb_mmu_table_walk_translate;
	import mtw_pkg::*;

	// Register indexes past the end of the register file; writes to them are dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 4'd8;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 4'd15;

	// Longest walk plus some slack
	localparam int DRAIN_CYCLES = 2 + 3 * MAX_STEPS_DEF + 8;

	typedef struct packed {
		logic [DATA_W-1:0] phys;
		logic              flt;
	} xlat_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DATA_W-1:0]    cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic                 cmd;
	logic [ADDR_FIELD_W-1:0] mem_addr;
	logic [DATA_W-1:0]    mem_data;
	logic [DATA_W-1:0]    virt_addr;
	logic                 out_valid;
	logic                 out_ready;
	logic [DATA_W-1:0]    phys_addr;
	logic                 fault;

	// Shadow of the descriptor RAM and of the register file
	logic [31:0] shadow_desc  [MEM_WORDS_DEF];
	bit          shadow_valid [MEM_WORDS_DEF];
	logic        sh_enable;
	logic [1:0]  sh_root_type;
	logic [27:0] sh_root_addr;
	logic [3:0]  sh_page_shift;
	logic [3:0]  sh_width [0:3];

	xlat_t       pending_xlat [$];
	xlat_t       exp_head;
	int          mismatches;
	int          beats_sent;
	int          send_idle_pct;
	int          recv_idle_pct;
	int          hold_cycles;
	logic [31:0] last_va;

	mmu_table_walk_translate u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.mem_addr  (mem_addr),
		.mem_data  (mem_data),
		.virt_addr (virt_addr),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.phys_addr (phys_addr),
		.fault     (fault)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Table index: the next wd address bits below offset off, zeros past bit 0
	function automatic logic [31:0] index_bits(input logic [31:0] va, input int off, input int wd);
		logic [63:0] shifted;
		if (wd == 0 || off >= 64)
			return 32'd0;
		shifted = {va, 32'd0} << off;
		shifted = shifted >> (64 - wd);
		return shifted[31:0];
	endfunction

	// Address bits not consumed as indices
	function automatic logic [31:0] low_bits(input logic [31:0] va, input int off);
		logic [63:0] mask;
		if (off >= 32)
			return 32'd0;
		mask = (64'd1 << (32 - off)) - 64'd1;
		return va & mask[31:0];
	endfunction

	// Walk the shadow tree; hole >= 0 names the first unwritten word the walk would read
	function automatic void walk_tree(input logic [31:0] va, output logic [31:0] pa,
			output logic flt, output int hole, output bit hole_second);
		logic [31:0] w0, w1, ptr, ptr2, pmask, idx;
		int lvl, off, steps, wd, wi, wi2;
		bit done;
		pa = va;
		flt = 1'b0;
		hole = -1;
		hole_second = 1'b0;
		done = !sh_enable;
		w0 = {30'd0, sh_root_type};
		w1 = {sh_root_addr, 4'd0};
		pmask = (32'd1 << sh_page_shift) - 32'd1;
		lvl = 0;
		off = 0;
		steps = 0;
		while (!done) begin
			if (w0[1:0] == DT_NONE) begin
				pa = 32'd0;
				flt = 1'b1;
				done = 1'b1;
			end else if (w0[1:0] == DT_PAGE) begin
				pa = (w1 & 32'hFFFF_FF00 & ~pmask) + low_bits(va, off);
				done = 1'b1;
			end else if (lvl >= 4 || steps >= MAX_STEPS_DEF) begin
				pa = 32'd0;
				flt = 1'b1;
				done = 1'b1;
			end else begin
				wd = int'(sh_width[lvl]);
				idx = index_bits(va, off, wd);
				ptr = (w1 & 32'hFFFF_FFF0) + idx * ((w0[1:0] == DT_LONG) ? 32'd8 : 32'd4);
				ptr2 = ptr + 32'd4;
				wi = (ptr >> 2) % MEM_WORDS_DEF;
				wi2 = (ptr2 >> 2) % MEM_WORDS_DEF;
				if (!shadow_valid[wi]) begin
					hole = wi;
					done = 1'b1;
				end else if (w0[1:0] == DT_LONG && !shadow_valid[wi2]) begin
					hole = wi2;
					hole_second = 1'b1;
					done = 1'b1;
				end else begin
					if (w0[1:0] == DT_LONG) begin
						w0 = shadow_desc[wi];
						w1 = shadow_desc[wi2];
					end else begin
						w0 = shadow_desc[wi];
						w1 = w0;
					end
					steps++;
					if (wd != 0) begin
						lvl++;
						off += wd;
					end
				end
			end
		end
	endfunction

	// Put random junk above the used bits of a register value
	function automatic logic [31:0] noisy(input logic [31:0] v, input int w);
		logic [31:0] n;
		n = $urandom();
		return (n << w) | v;
	endfunction

	function automatic logic [1:0] pick_type();
		int r;
		r = $urandom_range(99);
		if (r < 15)
			return DT_NONE;
		if (r < 40)
			return DT_PAGE;
		if (r < 70)
			return DT_SHORT;
		return DT_LONG;
	endfunction

	function automatic logic [31:0] rand_descriptor(input logic [1:0] dt);
		logic [31:0] n;
		n = $urandom();
		return {n[31:2], dt};
	endfunction

	task automatic flag_mismatch(input string what, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch on %s at %0t: expected %h, got %h", what, $time, exp_v, act_v);
	endtask

	// Write one configuration register and mirror it
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_TRANSLATE_ENABLE: sh_enable = data[0];
			REG_ROOT_TYPE:        sh_root_type = data[1:0];
			REG_ROOT_TABLE_ADDR:  sh_root_addr = data[27:0];
			REG_PAGE_SHIFT:       sh_page_shift = data[3:0];
			REG_WIDTH_A:          sh_width[0] = data[3:0];
			REG_WIDTH_B:          sh_width[1] = data[3:0];
			REG_WIDTH_C:          sh_width[2] = data[3:0];
			REG_WIDTH_D:          sh_width[3] = data[3:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Offer one beat after a random gap; record its result once accepted
	task automatic send_beat(input logic c, input logic [ADDR_FIELD_W-1:0] a,
			input logic [31:0] d, input logic [31:0] va);
		xlat_t r;
		int h;
		bit hs;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		mem_addr <= a;
		mem_data <= d;
		virt_addr <= va;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (c == CMD_WRITE) begin
			shadow_desc[a] = d;
			shadow_valid[a] = 1'b1;
			r.phys = 32'd0;
			r.flt = 1'b0;
		end else begin
			walk_tree(va, r.phys, r.flt, h, hs);
		end
		pending_xlat.push_back(r);
		beats_sent++;
	endtask

	task automatic store_word(input int a, input logic [31:0] d);
		send_beat(CMD_WRITE, a[ADDR_FIELD_W-1:0], d, $urandom());
	endtask

	task automatic translate_va(input logic [31:0] va);
		send_beat(CMD_TRANSLATE, ADDR_FIELD_W'($urandom_range(4095)), $urandom(), va);
		last_va = va;
	endtask

	// Drop valid, wait for every result, then let the back end settle
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_xlat.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	task automatic set_tree(input logic [1:0] rt, input logic [27:0] ra, input logic [3:0] ps,
			input int wa, input int wb, input int wc, input int wdd);
		wait_drained();
		write_reg(REG_ROOT_TYPE, noisy(32'(rt), 2));
		write_reg(REG_ROOT_TABLE_ADDR, noisy(32'(ra), 28));
		write_reg(REG_PAGE_SHIFT, noisy(32'(ps), 4));
		write_reg(REG_WIDTH_A, noisy(wa, 4));
		write_reg(REG_WIDTH_B, noisy(wb, 4));
		write_reg(REG_WIDTH_C, noisy(wc, 4));
		write_reg(REG_WIDTH_D, noisy(wdd, 4));
	endtask

	// Fill the holes on the walk of va (types from plan first), up to 24 stores, then translate it if none is left
	task automatic grow_and_translate(input logic [31:0] va, input logic [15:0] plan,
			input int plan_len);
		logic [31:0] pa;
		logic f;
		int hole, used, tries;
		bit second;
		used = 0;
		tries = 0;
		walk_tree(va, pa, f, hole, second);
		while (hole >= 0 && tries < 24) begin
			if (second) begin
				store_word(hole, $urandom());
			end else if (used < plan_len) begin
				store_word(hole, rand_descriptor(plan[2*used +: 2]));
				used++;
			end else begin
				store_word(hole, rand_descriptor(pick_type()));
			end
			tries++;
			walk_tree(va, pa, f, hole, second);
		end
		if (hole < 0)
			translate_va(va);
	endtask

	task automatic test_pass_through();
		write_reg(REG_TRANSLATE_ENABLE, noisy(0, 1));
		write_reg(REG_SPARE_LO, $urandom());
		write_reg(REG_SPARE_HI, $urandom());
		store_word(4095, 32'hFFFF_FFFF);
		store_word(0, 32'h0000_0000);
		translate_va(32'h0000_0000);
		translate_va(32'hFFFF_FFFF);
	endtask

	task automatic test_root_pointer();
		set_tree(DT_NONE, 28'h0, PAGE_SHIFT_RESET, 0, 0, 0, 0);
		write_reg(REG_TRANSLATE_ENABLE, noisy(1, 1));
		translate_va($urandom());
		set_tree(DT_PAGE, 28'hFFF_FFFF, 4'd15, 0, 0, 0, 0);
		translate_va(32'hFFFF_FFFF);
		set_tree(DT_PAGE, 28'($urandom()), 4'd0, 0, 0, 0, 0);
		translate_va($urandom());
	endtask

	task automatic test_short_walk();
		set_tree(DT_SHORT, 28'h100, PAGE_SHIFT_RESET, 4, 4, 4, 4);
		grow_and_translate($urandom(), {10'd0, DT_PAGE, DT_SHORT, DT_SHORT}, 3);
	endtask

	task automatic test_long_walk();
		set_tree(DT_LONG, 28'h200, 4'd8, 3, 5, 0, 2);
		grow_and_translate($urandom(), {12'd0, DT_PAGE, DT_LONG}, 2);
	endtask

	// Four table levels, then a table where a page is due
	task automatic test_level_overrun();
		set_tree(DT_SHORT, 28'h300, PAGE_SHIFT_RESET, 1, 1, 1, 1);
		grow_and_translate($urandom(), {8'd0, DT_SHORT, DT_SHORT, DT_SHORT, DT_SHORT}, 4);
	endtask

	// Zero widths and a table pointing at itself: re-read entry 0 until the step cap
	task automatic test_step_cap();
		logic [27:0] loop_tbl;
		logic [31:0] byte_addr;
		loop_tbl = 28'h380;
		byte_addr = {loop_tbl, 4'd0};
		set_tree(DT_SHORT, loop_tbl, PAGE_SHIFT_RESET, 0, 0, 0, 0);
		store_word((byte_addr >> 2) % MEM_WORDS_DEF, {loop_tbl, 2'b00, DT_SHORT});
		translate_va($urandom());
	endtask

	// Wide indices run past bit 0 and leave no page offset; the root address wraps
	task automatic test_deep_offset();
		set_tree(DT_SHORT, 28'hFFF_FFFF, 4'd15, 15, 15, 15, 15);
		grow_and_translate($urandom(), {10'd0, DT_PAGE, DT_SHORT, DT_SHORT}, 3);
	endtask

	// Stall the result side long enough to fill the block, keep offering beats
	task automatic test_backpressure();
		set_tree(DT_SHORT, 28'($urandom()), PAGE_SHIFT_RESET, 2, 2, 2, 2);
		hold_cycles = 200;
		repeat (6) begin
			store_word($urandom_range(4095), $urandom());
			grow_and_translate($urandom(), 16'd0, 0);
		end
		wait_drained();
	endtask

	task automatic run_random_phase(input int s_pct, input int r_pct, input int target);
		int start, chunk_end, r, hole;
		logic [31:0] va, pa;
		logic f;
		bit second;
		logic [1:0] rt;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		start = beats_sent;
		while (beats_sent - start < target) begin
			// Pick a fresh tree shape
			r = $urandom_range(99);
			rt = (r < 10) ? DT_NONE : (r < 20) ? DT_PAGE : (r < 60) ? DT_SHORT : DT_LONG;
			set_tree(rt, 28'($urandom()),
				4'(($urandom_range(99) < 80) ? $urandom_range(8, 15) : $urandom_range(0, 7)),
				($urandom_range(99) < 75) ? $urandom_range(0, 4) : $urandom_range(0, 15),
				($urandom_range(99) < 75) ? $urandom_range(0, 4) : $urandom_range(0, 15),
				($urandom_range(99) < 75) ? $urandom_range(0, 4) : $urandom_range(0, 15),
				($urandom_range(99) < 75) ? $urandom_range(0, 4) : $urandom_range(0, 15));
			write_reg(REG_TRANSLATE_ENABLE, noisy(($urandom_range(99) < 90) ? 1 : 0, 1));
			chunk_end = beats_sent + 40 + $urandom_range(30);
			while (beats_sent < chunk_end) begin
				r = $urandom_range(99);
				if (r < 55) begin
					// Well-formed walk, often sharing the upper path of the last one
					va = $urandom();
					if ($urandom_range(99) < 60)
						va = (last_va & (32'hFFFF_FFFF << $urandom_range(4, 28))) |
							(va & ~(32'hFFFF_FFFF << $urandom_range(4, 28)));
					grow_and_translate(va, 16'd0, 0);
				end else if (r < 75) begin
					store_word($urandom_range(4095), $urandom());
				end else if (r < 90) begin
					// Bare translate; where it would hit a hole, patch one word instead
					va = $urandom();
					walk_tree(va, pa, f, hole, second);
					if (hole < 0)
						translate_va(va);
					else
						store_word(hole, $urandom());
				end else begin
					store_word($urandom_range(4095), rand_descriptor(pick_type()));
				end
			end
		end
	endtask

	// Result side: random ready, or a counted hold-off
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_ready <= 1'b0;
			hold_cycles = hold_cycles - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Compare each result beat with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_xlat.size() == 0) begin
				flag_mismatch("unexpected result", 32'd0, phys_addr);
			end else begin
				exp_head = pending_xlat.pop_front();
				if (phys_addr !== exp_head.phys)
					flag_mismatch("phys_addr", exp_head.phys, phys_addr);
				if (fault !== exp_head.flt)
					flag_mismatch("fault", {31'd0, exp_head.flt}, {31'd0, fault});
			end
		end
	end

	initial begin
		#8_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		cmd = CMD_WRITE;
		mem_addr = '0;
		mem_data = '0;
		virt_addr = '0;
		out_ready = 1'b0;
		mismatches = 0;
		beats_sent = 0;
		hold_cycles = 0;
		send_idle_pct = 36;
		recv_idle_pct = 66;
		last_va = '0;
		sh_enable = 1'b0;
		sh_root_type = DT_NONE;
		sh_root_addr = '0;
		sh_page_shift = PAGE_SHIFT_RESET;
		for (int i = 0; i < 4; i++)
			sh_width[i] = 4'd0;
		for (int i = 0; i < MEM_WORDS_DEF; i++) begin
			shadow_desc[i] = 32'd0;
			shadow_valid[i] = 1'b0;
		end
		repeat (2)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_pass_through();
		test_root_pointer();
		test_short_walk();
		test_long_walk();
		test_level_overrun();
		test_step_cap();
		test_deep_offset();
		test_backpressure();
		run_random_phase(36, 66, 210);
		run_random_phase(66, 36, 210);
		run_random_phase(0, 0, 210);
		wait_drained();

		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
